>>> sv/sfr_pkg.sv
package sfr_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_BITS    = 11;
    localparam int BYTE_BITS    = 8;
    localparam int FRAME_BITS   = FRAME_BYTES * BYTE_BITS;
    localparam int FILL_W       = $clog2(FRAME_BYTES + 1);
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int ANGLE_W      = 16;

    // Offset times a full turn in Q7 fits in 27 bits.
    localparam int NUM_W        = 27;
    localparam int STEP_W       = $clog2(NUM_W + 1);

    localparam logic [ANGLE_W-1:0] FULL_TURN_Q7 = 16'd46080;
    localparam logic [ANGLE_W-1:0] HALF_TURN_Q7 = 16'd23040;

    localparam int LOST_BIT = 2;
    localparam int SAFE_BIT = 3;

    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_SPAN_LOW     = 2'd2,
        REG_SPAN_HIGH    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                 start;
        logic [NUM_W-1:0]     num;
        logic [CHAN_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> sv/sfr_div.sv
module sfr_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfr_pkg::t_div_req i_req,
    output sfr_pkg::t_div_rsp o_rsp
);

    logic [sfr_pkg::NUM_W-1:0]     r_quo;
    logic [sfr_pkg::CHAN_BITS-1:0] r_rem;
    logic [sfr_pkg::CHAN_BITS-1:0] r_den;
    logic [sfr_pkg::STEP_W-1:0]    r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [sfr_pkg::CHAN_BITS:0]   shifted;
    logic                          fits;
    logic [sfr_pkg::CHAN_BITS:0]   diff;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        shifted = {r_rem, r_quo[sfr_pkg::NUM_W-1]};
        fits    = (shifted >= {1'b0, r_den});
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= sfr_pkg::STEP_W'(sfr_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == sfr_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= {r_quo[sfr_pkg::NUM_W-2:0], fits};
            r_rem <= fits ? diff[sfr_pkg::CHAN_BITS-1:0] : shifted[sfr_pkg::CHAN_BITS-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo[sfr_pkg::ANGLE_W-1:0];

endmodule

>>> sv/sbus_frame_receiver_unit.sv
// Bytes are taken one per cycle while the unit is idle; each byte that does not close a frame
// gives no result. After the closing byte of a good frame, 16 words follow: channels 0 and 1
// go through clamp, multiply, 27-step shared divider and output when span high exceeds span
// low, the others through clamp and output only. No byte is taken meanwhile.
// Reset (synchronous, active low) empties the frame and restores the register defaults.
module sbus_frame_receiver_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [3:0]                   o_chan_num,
    output logic [10:0]                  o_chan_value,
    output logic signed [15:0]           o_angle_q7,
    output logic                         o_lost_flag,
    output logic                         o_safe_flag,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0]   paddr,
    input  logic [sfr_pkg::DATA_W-1:0]   pwdata,
    output logic [sfr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHAN = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]                      r_start_marker;
    logic [7:0]                      r_end_marker;
    logic [sfr_pkg::CHAN_BITS-1:0]   r_span_low;
    logic [sfr_pkg::CHAN_BITS-1:0]   r_span_high;

    logic [sfr_pkg::FRAME_BITS-1:0]  r_frame;
    logic [sfr_pkg::FILL_W-1:0]      r_fill;
    logic [sfr_pkg::CH_W-1:0]        r_ch;
    logic [sfr_pkg::CHAN_BITS-1:0]   r_raw;
    logic [sfr_pkg::CHAN_BITS-1:0]   r_off;
    logic signed [sfr_pkg::ANGLE_W-1:0] r_angle;
    logic                            r_lost;
    logic                            r_safe;

    logic                            in_acc;
    logic                            out_acc;
    logic                            cfg_wr;
    logic                            frame_done;
    logic                            frame_good;
    logic                            need_angle;
    logic [sfr_pkg::CHAN_BITS-1:0]   raw_now;
    logic [sfr_pkg::CHAN_BITS-1:0]   clamped;
    logic [7:0]                      flag_byte;
    sfr_pkg::t_div_req               div_req;
    sfr_pkg::t_div_rsp               div_rsp;

    function automatic sfr_pkg::t_reg_idx reg_idx_of(input logic [sfr_pkg::ADDR_W-1:0] addr);
        return sfr_pkg::t_reg_idx'(addr[sfr_pkg::ADDR_W-1:2]);
    endfunction

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid & ~o_stall;
    assign o_valid = (r_state == S_EMIT);
    assign out_acc = o_valid & ~i_stall;

    // Bytes enter at the top of the frame line, so after the 24th byte the first frame byte
    // sits in the second lowest byte lane and the flag byte in the top lane.
    assign frame_done = in_acc && (r_fill == sfr_pkg::FILL_W'(sfr_pkg::FRAME_BYTES - 1));
    assign frame_good = (r_frame[15:8] == r_start_marker) && (i_rx_byte == r_end_marker);
    assign flag_byte  = r_frame[sfr_pkg::FRAME_BITS-1 -: 8];

    assign raw_now    = r_frame[8 +: sfr_pkg::CHAN_BITS];
    assign need_angle = (r_ch < sfr_pkg::CH_W'(2)) && (r_span_high > r_span_low);

    always_comb begin
        if (raw_now < r_span_low) begin
            clamped = r_span_low;
        end else if (raw_now > r_span_high) begin
            clamped = r_span_high;
        end else begin
            clamped = raw_now;
        end
    end

    assign div_req.start = (r_state == S_MUL);
    assign div_req.num   = sfr_pkg::NUM_W'(r_off) * sfr_pkg::NUM_W'(sfr_pkg::FULL_TURN_Q7);
    assign div_req.den   = r_span_high - r_span_low;

    sfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (frame_done && frame_good) begin
                    n_state = S_CHAN;
                end
            end
            S_CHAN: begin
                n_state = need_angle ? S_MUL : S_EMIT;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    n_state = (r_ch == sfr_pkg::CH_W'(sfr_pkg::NUM_CHANNELS - 1)) ? S_IDLE : S_CHAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fill         <= '0;
            r_ch           <= '0;
            r_start_marker <= 8'h0F;
            r_end_marker   <= 8'h00;
            r_span_low     <= 11'd172;
            r_span_high    <= 11'd1811;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (frame_done) begin
                    r_fill <= '0;
                end else if (r_fill != '0 || i_rx_byte == r_start_marker) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_state == S_IDLE) begin
                r_ch <= '0;
            end else if (out_acc) begin
                r_ch <= r_ch + 1'b1;
            end
            if (cfg_wr) begin
                case (reg_idx_of(paddr))
                    sfr_pkg::REG_START_MARKER: r_start_marker <= pwdata[7:0];
                    sfr_pkg::REG_END_MARKER:   r_end_marker   <= pwdata[7:0];
                    sfr_pkg::REG_SPAN_LOW:     r_span_low     <= pwdata[sfr_pkg::CHAN_BITS-1:0];
                    sfr_pkg::REG_SPAN_HIGH:    r_span_high    <= pwdata[sfr_pkg::CHAN_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (r_fill != '0 || i_rx_byte == r_start_marker)) begin
            r_frame <= {i_rx_byte, r_frame[sfr_pkg::FRAME_BITS-1:8]};
        end else if (r_state == S_CHAN) begin
            r_frame <= {{sfr_pkg::CHAN_BITS{1'b0}},
                        r_frame[sfr_pkg::FRAME_BITS-1:sfr_pkg::CHAN_BITS]};
        end
        if (frame_done) begin
            r_lost <= flag_byte[sfr_pkg::LOST_BIT];
            r_safe <= flag_byte[sfr_pkg::SAFE_BIT];
        end
        if (r_state == S_CHAN) begin
            r_raw   <= raw_now;
            r_off   <= clamped - r_span_low;
            r_angle <= '0;
        end
        if (r_state == S_DIV && div_rsp.done) begin
            r_angle <= $signed(div_rsp.quot - sfr_pkg::HALF_TURN_Q7);
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx_of(paddr))
            sfr_pkg::REG_START_MARKER: prdata = sfr_pkg::DATA_W'(r_start_marker);
            sfr_pkg::REG_END_MARKER:   prdata = sfr_pkg::DATA_W'(r_end_marker);
            sfr_pkg::REG_SPAN_LOW:     prdata = sfr_pkg::DATA_W'(r_span_low);
            sfr_pkg::REG_SPAN_HIGH:    prdata = sfr_pkg::DATA_W'(r_span_high);
            default:                   prdata = '0;
        endcase
    end

    assign o_chan_num   = r_ch;
    assign o_chan_value = r_raw;
    assign o_angle_q7   = r_angle;
    assign o_lost_flag  = r_lost;
    assign o_safe_flag  = r_safe;
    assign o_last       = (r_ch == sfr_pkg::CH_W'(sfr_pkg::NUM_CHANNELS - 1));

    a_no_byte_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("byte port open while a word is pending");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < sfr_pkg::FILL_W'(sfr_pkg::FRAME_BYTES))
        else $error("fill count ran past the frame length");

    a_angle_zero_high_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_chan_num >= 4'd2)) |-> (o_angle_q7 == '0))
        else $error("angle set on a channel without angle mapping");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> (r_state == S_IDLE))
        else $error("decoder did not return to idle after the last channel");

    a_div_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

endmodule
